// File: hw/rtl/lfst_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the lowest free slot table.
// Depends on nothing; every other file but lfst_ram refers to it, the RTL by scoped names.
package lfst_pkg;

	// Table geometry. Sizes run from zero to CAPACITY, so they need one bit more than an index.
	localparam int CAPACITY       = 256;
	localparam int IDX_W          = $clog2(CAPACITY);
	localparam int SIZE_W         = IDX_W + 1;
	localparam int VALUE_BITS_DEF = 32;

	// The occupancy search looks at the bitmap in groups of this many slots.
	localparam int GROUP_W   = 16;
	localparam int GROUP_CNT = CAPACITY / GROUP_W;
	localparam int GRP_W     = $clog2(GROUP_CNT);
	localparam int BIT_W     = $clog2(GROUP_W);

	localparam int ACT_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIZE_W;

	// Actions.
	localparam logic [ACT_W-1:0] ACT_INIT         = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD          = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET          = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TEST_AND_SET = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SET_SIZE     = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_ROOM   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_IN_USE    = 2'd2;
	localparam logic [STATUS_W-1:0] STS_BAD_PARAM = 2'd3;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ENTRIES = 2'd2;

	localparam logic [SIZE_W-1:0] RST_MAX_ENTRIES     = 9'd256;
	localparam logic [SIZE_W-1:0] RST_GROW_STEP       = 9'd32;
	localparam logic [SIZE_W-1:0] RST_INITIAL_ENTRIES = 9'd0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;      // capture the accepted request word, start the slot read
		logic exec;       // carry out the action
		logic grow_iter;  // one growth step of set_size
		logic search;     // first stage of the lowest free slot search
		logic load_out;   // finish the search and load the result word
	} lfst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic resize;       // the current action is set_size
		logic resize_done;  // set_size has reached its size or failed
	} lfst_stat_t;

endpackage

// File: hw/rtl/lfst_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the lowest free slot table: request, result, configuration.
// Depends on lfst_pkg.
interface lfst_req_if #(
	parameter int VALUE_BITS = lfst_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [lfst_pkg::ACT_W-1:0]   action;
	logic [lfst_pkg::IDX_W-1:0]   slot_index;
	logic [VALUE_BITS-1:0]        handle_value;
	logic [lfst_pkg::SIZE_W-1:0]  requested_size;

	modport source (output valid, action, slot_index, handle_value, requested_size, input ready);
	modport sink   (input valid, action, slot_index, handle_value, requested_size, output ready);
endinterface

interface lfst_res_if;
	logic                           valid;
	logic                           ready;
	logic [lfst_pkg::STATUS_W-1:0]  status;
	logic [lfst_pkg::IDX_W-1:0]     location;
	logic [lfst_pkg::SIZE_W-1:0]    current_size;
	logic [lfst_pkg::SIZE_W-1:0]    free_count;
	logic [lfst_pkg::SIZE_W-1:0]    first_free;

	modport source (output valid, status, location, current_size, free_count, first_free,
		input ready);
	modport sink   (input valid, status, location, current_size, free_count, first_free,
		output ready);
endinterface

interface lfst_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lfst_pkg::CFG_IDX_W-1:0]   index;
	logic [lfst_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/lfst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lfst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/lfst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the lowest free slot table: handshakes and the command per cycle.
// Depends on lfst_pkg.
module lfst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	input  lfst_pkg::lfst_stat_t stat,
	output lfst_pkg::lfst_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_GROW  = 3'd2;
	localparam logic [2:0] S_SRCH1 = 3'd3;
	localparam logic [2:0] S_SRCH2 = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_valid_q;
	logic       out_free;

	// The result register may be reloaded when it is empty or its word leaves now.
	assign out_free  = !res_valid_q || res_ready;
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.resize ? S_GROW : S_SRCH1;
			end
			S_GROW: begin
				cmd.grow_iter = 1'b1;
				if (stat.resize_done) begin
					state_d = S_SRCH1;
				end
			end
			S_SRCH1: begin
				cmd.search = 1'b1;
				state_d    = S_SRCH2;
			end
			S_SRCH2: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/lfst_dp.sv
`timescale 1ns / 1ps
// Datapath of the lowest free slot table: registers, occupancy bitmap, slot RAM, search.
// Depends on lfst_pkg and lfst_ram.
module lfst_dp #(
	parameter int VALUE_BITS = lfst_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lfst_pkg::lfst_cmd_t             cmd,
	output lfst_pkg::lfst_stat_t            stat,
	input  logic [lfst_pkg::ACT_W-1:0]      req_action,
	input  logic [lfst_pkg::IDX_W-1:0]      req_slot_index,
	input  logic [VALUE_BITS-1:0]           req_handle_value,
	input  logic [lfst_pkg::SIZE_W-1:0]     req_requested_size,
	input  logic                            cfg_we,
	input  logic [lfst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfst_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [lfst_pkg::STATUS_W-1:0]   res_status,
	output logic [lfst_pkg::IDX_W-1:0]      res_location,
	output logic [lfst_pkg::SIZE_W-1:0]     res_current_size,
	output logic [lfst_pkg::SIZE_W-1:0]     res_free_count,
	output logic [lfst_pkg::SIZE_W-1:0]     res_first_free
);

	localparam int CAP    = lfst_pkg::CAPACITY;
	localparam int IDX_W  = lfst_pkg::IDX_W;
	localparam int SIZE_W = lfst_pkg::SIZE_W;
	localparam int GW     = lfst_pkg::GROUP_W;
	localparam int GCNT   = lfst_pkg::GROUP_CNT;
	localparam int GRP_W  = lfst_pkg::GRP_W;
	localparam int BIT_W  = lfst_pkg::BIT_W;
	localparam logic [SIZE_W-1:0] CAP_SZ = SIZE_W'(CAP);

	// Configuration.
	logic [SIZE_W-1:0] max_q;
	logic [SIZE_W-1:0] step_q;
	logic [SIZE_W-1:0] init_q;

	// Captured request word.
	logic [lfst_pkg::ACT_W-1:0] action_q;
	logic [IDX_W-1:0]           idx_q;
	logic [VALUE_BITS-1:0]      val_q;
	logic [SIZE_W-1:0]          reqsz_q;

	// Table state. A bitmap bit is set exactly when its slot was last written nonzero since the last init.
	logic [SIZE_W-1:0]          size_q;
	logic [SIZE_W-1:0]          cnt_q;   // occupied slots
	logic [SIZE_W-1:0]          ff_q;    // lowest free slot, or size when full
	logic [CAP-1:0]             occ_q;
	logic [lfst_pkg::STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]           loc_q;

	// Search stage.
	logic [GRP_W-1:0] grp_s1;
	logic             found_s1;

	logic [VALUE_BITS-1:0] ram_rdata;

	// Growth arithmetic.
	logic [SIZE_W-1:0] limit;
	logic [SIZE_W-1:0] room;
	logic [SIZE_W-1:0] grown;
	logic              grow_ok;
	logic              need_more;

	// Action decision.
	logic [lfst_pkg::STATUS_W-1:0] ex_status;
	logic [IDX_W-1:0]              ex_loc;
	logic [SIZE_W-1:0]             ex_size;
	logic                          ex_write;
	logic                          ex_clear;
	logic [IDX_W-1:0]              ex_waddr;
	logic [SIZE_W-1:0]             init_sz;
	logic                          val_nz;
	logic                          in_use;
	logic                          occ_w;

	// Search results.
	logic [GRP_W-1:0]  grp_d;
	logic              found_d;
	logic [GW-1:0]     grp_word;
	logic [BIT_W-1:0]  bit_d;
	logic              bit_found;
	logic [SIZE_W-1:0] first_zero;
	logic [SIZE_W-1:0] ff_next;

	lfst_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(CAP)
	) u_ram (
		.clk  (clk),
		.we   (cmd.exec && ex_write),
		.waddr(ex_waddr),
		.wdata(val_q),
		.re   (cmd.latch),
		.raddr(req_slot_index),
		.rdata(ram_rdata)
	);

	// One growth step: add grow_step, stopping exactly at the limit.
	assign limit     = (max_q < CAP_SZ) ? max_q : CAP_SZ;
	assign grow_ok   = (size_q < limit) && (step_q != '0);
	assign room      = limit - size_q;
	assign grown     = (step_q > room) ? limit : size_q + step_q;
	assign need_more = reqsz_q > size_q;

	assign stat.resize      = (action_q == lfst_pkg::ACT_SET_SIZE);
	assign stat.resize_done = !need_more || !grow_ok;

	assign val_nz  = (val_q != '0);
	// The bitmap gates stale RAM contents left from before the last init.
	assign in_use  = occ_q[idx_q] && (ram_rdata != '0);
	assign init_sz = (init_q != '0) ? init_q : step_q;
	assign occ_w   = occ_q[ex_waddr];

	always_comb begin
		ex_status = lfst_pkg::STS_OK;
		ex_loc    = '0;
		ex_size   = size_q;
		ex_write  = 1'b0;
		ex_clear  = 1'b0;
		ex_waddr  = idx_q;
		unique case (action_q)
			lfst_pkg::ACT_INIT: begin
				if (max_q < step_q) begin
					ex_status = lfst_pkg::STS_BAD_PARAM;
				end else begin
					ex_clear = 1'b1;
					ex_size  = (init_sz > CAP_SZ) ? CAP_SZ : init_sz;
				end
			end
			lfst_pkg::ACT_ADD: begin
				// When full, the lowest free slot after one growth is the old size.
				ex_waddr = ff_q[IDX_W-1:0];
				if (cnt_q == size_q && !grow_ok) begin
					ex_status = lfst_pkg::STS_NO_ROOM;
				end else begin
					if (cnt_q == size_q) begin
						ex_size = grown;
					end
					ex_loc   = ff_q[IDX_W-1:0];
					ex_write = 1'b1;
				end
			end
			lfst_pkg::ACT_SET, lfst_pkg::ACT_TEST_AND_SET: begin
				if (action_q == lfst_pkg::ACT_TEST_AND_SET && in_use) begin
					ex_status = lfst_pkg::STS_IN_USE;
				end else if ({1'b0, idx_q} >= size_q) begin
					if (!grow_ok) begin
						ex_status = lfst_pkg::STS_NO_ROOM;
					end else begin
						ex_size = grown;
						if ({1'b0, idx_q} >= grown) begin
							ex_status = lfst_pkg::STS_NO_ROOM;
						end else begin
							ex_write = 1'b1;
						end
					end
				end else begin
					ex_write = 1'b1;
				end
			end
			lfst_pkg::ACT_SET_SIZE: begin
				ex_status = lfst_pkg::STS_OK;
			end
			default: begin
				ex_status = lfst_pkg::STS_BAD_PARAM;
			end
		endcase
	end

	// First search stage: lowest group with a clear bitmap bit.
	always_comb begin
		grp_d   = '0;
		found_d = 1'b0;
		for (int g = GCNT - 1; g >= 0; g--) begin
			if (!(&occ_q[g*GW +: GW])) begin
				grp_d   = GRP_W'(g);
				found_d = 1'b1;
			end
		end
	end

	// Second stage: lowest clear bit inside that group, cut to the size.
	assign grp_word = occ_q[{grp_s1, {BIT_W{1'b0}}} +: GW];

	always_comb begin
		bit_d     = '0;
		bit_found = 1'b0;
		for (int b = GW - 1; b >= 0; b--) begin
			if (!grp_word[b]) begin
				bit_d     = BIT_W'(b);
				bit_found = 1'b1;
			end
		end
	end

	assign first_zero = (found_s1 && bit_found) ? SIZE_W'({grp_s1, bit_d}) : CAP_SZ;
	assign ff_next    = (first_zero < size_q) ? first_zero : size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= lfst_pkg::RST_MAX_ENTRIES;
			step_q <= lfst_pkg::RST_GROW_STEP;
			init_q <= lfst_pkg::RST_INITIAL_ENTRIES;
			size_q <= '0;
			cnt_q  <= '0;
			ff_q   <= '0;
			occ_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lfst_pkg::CFG_MAX_ENTRIES:     max_q  <= cfg_data;
					lfst_pkg::CFG_GROW_STEP:       step_q <= cfg_data;
					lfst_pkg::CFG_INITIAL_ENTRIES: init_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				size_q <= ex_size;
				if (ex_clear) begin
					occ_q <= '0;
					cnt_q <= '0;
				end else if (ex_write) begin
					occ_q[ex_waddr] <= val_nz;
					if (val_nz && !occ_w) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!val_nz && occ_w) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
			if (cmd.grow_iter && need_more && grow_ok) begin
				size_q <= grown;
			end
			if (cmd.load_out) begin
				ff_q <= ff_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= req_action;
			idx_q    <= req_slot_index;
			val_q    <= req_handle_value;
			reqsz_q  <= req_requested_size;
		end
		if (cmd.exec) begin
			status_q <= ex_status;
			loc_q    <= ex_loc;
		end
		if (cmd.grow_iter && need_more && !grow_ok) begin
			status_q <= lfst_pkg::STS_NO_ROOM;
		end
		if (cmd.search) begin
			grp_s1   <= grp_d;
			found_s1 <= found_d;
		end
		if (cmd.load_out) begin
			res_status       <= status_q;
			res_location     <= loc_q;
			res_current_size <= size_q;
			res_free_count   <= size_q - cnt_q;
			res_first_free   <= ff_next;
		end
	end

endmodule

// File: hw/rtl/lowest_free_slot_table.sv
`timescale 1ns / 1ps
// Top level of the lowest free slot table: handle table with lowest-free allocation.
// Depends on lfst_pkg, lfst_if, lfst_ctrl, lfst_dp and lfst_ram.
//
// Usage. Requests arrive as words on the request channel (action, slot index, handle value,
// requested size); each request yields exactly one result word on the result channel with the
// status, the slot chosen by add, and the size, free count and lowest free slot afterwards.
// Configuration words (max_entries, grow_step, initial_entries at indexes 0, 1 and 2) are
// taken on the cfg channel in any cycle; ready is always high there, and writes should only
// be issued while no request is in flight.
//
// Sequence. A request word is taken in S_IDLE, the action is carried out in S_EXEC, and the
// bitmap search in S_SRCH1 and S_SRCH2 finds the lowest free slot before the result is loaded.
// set_size passes through S_GROW between S_EXEC and S_SRCH1, where its loop grows the table
// by one step per cycle through the shared grow adder. Only one request is in work at a time.
//
// Stalls. The result register holds its word until it is taken; the next request may be
// accepted meanwhile, and its result waits in the last search cycle until the register frees.
//
// Reset. After arst_n the table is empty with size zero and the configuration holds its reset
// values; the occupancy bitmap is cleared at once, so no clearing pass over the slot RAM runs.
module lowest_free_slot_table #(
	parameter int VALUE_BITS = lfst_pkg::VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lfst_req_if.sink  request,
	lfst_res_if.source result,
	lfst_cfg_if.sink  cfg
);

	lfst_pkg::lfst_cmd_t  cmd;
	lfst_pkg::lfst_stat_t stat;

	// Configuration writes never stall.
	assign cfg.ready = 1'b1;

	// The controller owns the request and result handshakes and sequences the datapath.
	lfst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(request.valid),
		.req_ready(request.ready),
		.res_valid(result.valid),
		.res_ready(result.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the table state, the slot RAM and the result register.
	lfst_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.req_action        (request.action),
		.req_slot_index    (request.slot_index),
		.req_handle_value  (request.handle_value),
		.req_requested_size(request.requested_size),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.res_status        (result.status),
		.res_location      (result.location),
		.res_current_size  (result.current_size),
		.res_free_count    (result.free_count),
		.res_first_free    (result.first_free)
	);

endmodule

// File: hw/rtl/lfst_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the lowest free slot table, attached to the top level by bind.
// Depends on lfst_pkg and lowest_free_slot_table.
module lfst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [lfst_pkg::SIZE_W-1:0] res_current_size,
	input logic [lfst_pkg::SIZE_W-1:0] res_free_count,
	input logic [lfst_pkg::SIZE_W-1:0] res_first_free
);

	// A stalled result word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_current_size) &&
			$stable(res_free_count) && $stable(res_first_free)))
		else $error("result word changed while stalled");

	// Only one request is in work: the block is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while the previous one is in work");

	// The free count never exceeds the size.
	a_free_le_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_free_count <= res_current_size))
		else $error("free count above the table size");

	// The lowest free slot equals the size exactly when no slot is free.
	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_free_count == '0) == (res_first_free == res_current_size)))
		else $error("lowest free slot disagrees with the free count");

	// The lowest free slot lies within the table.
	a_first_le_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_first_free <= res_current_size))
		else $error("lowest free slot beyond the table size");

endmodule

bind lowest_free_slot_table lfst_checker u_lfst_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (request.valid),
	.req_ready       (request.ready),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_current_size(result.current_size),
	.res_free_count  (result.free_count),
	.res_first_free  (result.first_free)
);

// File: bench/lowest_free_slot_table_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lowest_free_slot_table: directed and random request words against a
// behavioral slot table model. Depends on lfst_pkg, lfst_if and the table RTL.
module lowest_free_slot_table_tb;
	import lfst_pkg::*;

	localparam int VALUE_W        = VALUE_BITS_DEF;
	// Longest legal quiet stretch is a set_size that grows one slot per cycle up to CAPACITY,
	// plus a long receiver stall; this is many times that.
	localparam int WATCHDOG_LIMIT = 4000;
	// Covers the turnaround of a request with room to spare.
	localparam int SETTLE_CYCLES  = 12;
	localparam int MAX_REPORTS    = 10;

	// The configuration port decodes a fourth index that maps to no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX  = 2'd3;
	localparam logic [ACT_W-1:0]     ACT_FIRST_UNUSED = ACT_SET_SIZE + 3'd1;
	localparam logic [ACT_W-1:0]     ACT_LAST_UNUSED  = {ACT_W{1'b1}};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    location;
		logic [SIZE_W-1:0]   current_size;
		logic [SIZE_W-1:0]   free_count;
		logic [SIZE_W-1:0]   first_free;
	} slot_result_t;

	logic clk;
	logic arst_n;

	lfst_req_if #(.VALUE_BITS(VALUE_W)) req_ch ();
	lfst_res_if                         res_ch ();
	lfst_cfg_if                         cfg_ch ();

	lowest_free_slot_table #(.VALUE_BITS(VALUE_W)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (res_ch),
		.cfg     (cfg_ch)
	);

	// Shadow copy of the table contents, its bookkeeping and the three registers.
	logic [VALUE_W-1:0] model_slots [CAPACITY];
	int model_size;
	int model_free;
	int model_lowest;
	int cfg_max;
	int cfg_step;
	int cfg_initial;

	// Result words predicted for accepted requests, oldest first.
	slot_result_t pending_results [$];

	int fail_count    = 0;
	int reports_shown = 0;
	int idle_cycles   = 0;
	int sender_idle_pct;
	int receiver_stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------------------
	// Table model
	// ------------------------------------------------------------------------------------

	// Recount empty slots below the size and find the lowest one (the size itself if none).
	function automatic void rescan_table();
		int cnt;
		int low;
		cnt = 0;
		low = model_size;
		for (int i = 0; i < model_size && i < CAPACITY; i++) begin
			if (model_slots[i] == '0) begin
				if (low == model_size)
					low = i;
				cnt++;
			end
		end
		model_free   = cnt;
		model_lowest = low;
	endfunction

	// One growth step: add grow_step slots, or fewer to land exactly on the limit.
	function automatic bit model_grow();
		int limit;
		limit = (cfg_max < CAPACITY) ? cfg_max : CAPACITY;
		if (model_size >= limit || cfg_step == 0)
			return 1'b0;
		if (cfg_step > limit - model_size)
			model_size = limit;
		else
			model_size += cfg_step;
		return 1'b1;
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < CAPACITY; i++)
			model_slots[i] = '0;
	endfunction

	// Carries one request through the model and returns the result word it must produce.
	function automatic slot_result_t predict_table_step(input logic [ACT_W-1:0] act,
			input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] val,
			input logic [SIZE_W-1:0] req);
		slot_result_t r;
		int start_size;
		bit failed;
		r          = '0;
		r.status   = STS_OK;
		r.location = '0;
		failed     = 1'b0;
		case (act)
			ACT_INIT: begin
				// Rejected outright when the step would already overshoot the maximum.
				if (cfg_max < cfg_step) begin
					r.status = STS_BAD_PARAM;
				end else begin
					start_size = (cfg_initial != 0) ? cfg_initial : cfg_step;
					clear_slots();
					model_size = (start_size < CAPACITY) ? start_size : CAPACITY;
				end
			end
			ACT_ADD: begin
				if (model_free == 0 && !model_grow()) begin
					r.status = STS_NO_ROOM;
				end else begin
					rescan_table();
					if (model_lowest < model_size) begin
						// A zero value is reported at this slot but leaves it free.
						r.location                = model_lowest[IDX_W-1:0];
						model_slots[model_lowest] = val;
					end else begin
						r.status = STS_NO_ROOM;
					end
				end
			end
			ACT_SET, ACT_TEST_AND_SET: begin
				if (act == ACT_TEST_AND_SET && idx < model_size && model_slots[idx] != '0) begin
					r.status = STS_IN_USE;
				end else if (idx >= model_size) begin
					// Only one growth step is tried; the growth stays even if it falls short.
					if (!model_grow() || idx >= model_size)
						r.status = STS_NO_ROOM;
					else
						model_slots[idx] = val;
				end else begin
					model_slots[idx] = val;
				end
			end
			ACT_SET_SIZE: begin
				while (!failed && req > model_size) begin
					if (!model_grow())
						failed = 1'b1;
				end
				if (failed)
					r.status = STS_NO_ROOM;
			end
			default: begin
				r.status = STS_BAD_PARAM;
			end
		endcase
		rescan_table();
		r.current_size = model_size[SIZE_W-1:0];
		r.free_count   = model_free[SIZE_W-1:0];
		r.first_free   = model_lowest[SIZE_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------------------
	// Channel drivers and result checker
	// ------------------------------------------------------------------------------------

	// The receiver stalls at random; a new decision is made every falling edge.
	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
	end

	// Every result word taken from the block is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		slot_result_t got;
		slot_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.status       = res_ch.status;
			got.location     = res_ch.location;
			got.current_size = res_ch.current_size;
			got.free_count   = res_ch.free_count;
			got.first_free   = res_ch.first_free;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (reports_shown < MAX_REPORTS) begin
					reports_shown++;
					$display("%0t: result word with no request outstanding: status=%0d loc=%0d",
						$realtime, got.status, got.location);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (reports_shown < MAX_REPORTS) begin
						reports_shown++;
						$display("%0t: expected status=%0d loc=%0d size=%0d free=%0d first=%0d",
							$realtime, want.status, want.location, want.current_size,
							want.free_count, want.first_free);
						$display("%0t:   actual status=%0d loc=%0d size=%0d free=%0d first=%0d",
							$realtime, got.status, got.location, got.current_size,
							got.free_count, got.first_free);
					end
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which no channel moves a word.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one request word, possibly after a random gap, and returns once it is taken.
	// Valid stays high afterwards so that a following word can go out back to back.
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] val, input logic [SIZE_W-1:0] req);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid          = 1'b1;
		req_ch.action         = act;
		req_ch.slot_index     = idx;
		req_ch.handle_value   = val;
		req_ch.requested_size = req;
		// Requests are handled strictly in order, so predicting now matches acceptance order.
		pending_results.push_back(predict_table_step(act, idx, val, req));
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Stops offering requests and waits until every predicted word has come back.
	task automatic wait_until_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] reg_idx, input int value);
		logic [CFG_DATA_W-1:0] word_data;
		word_data = value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = reg_idx;
		cfg_ch.data  = word_data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (reg_idx)
			CFG_MAX_ENTRIES:     cfg_max     = int'(word_data);
			CFG_GROW_STEP:       cfg_step    = int'(word_data);
			CFG_INITIAL_ENTRIES: cfg_initial = int'(word_data);
			default:             ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Registers change only with the block idle.
	task automatic configure_table(input int max_e, input int step, input int init_e);
		wait_until_drained();
		write_register(CFG_MAX_ENTRIES, max_e);
		write_register(CFG_GROW_STEP, step);
		write_register(CFG_INITIAL_ENTRIES, init_e);
	endtask

	// ------------------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------------------

	// Reset configuration: lazy first growth, zero values, indexes beyond the size, a full
	// grow to capacity, oversize requests and the unused action codes.
	task automatic test_after_reset();
		send_request(ACT_SET_SIZE, '0, '0, 9'd0);
		send_request(ACT_ADD, '0, 32'hFFFF_FFFF, '0);
		send_request(ACT_ADD, '0, 32'h0, '0);
		// Still beyond the size after one growth step, so the write is refused.
		send_request(ACT_SET, 8'd255, 32'h1, '0);
		send_request(ACT_TEST_AND_SET, 8'd0, 32'h5, '0);
		send_request(ACT_TEST_AND_SET, 8'd1, 32'h0, '0);
		send_request(ACT_SET, 8'd0, 32'h0, '0);
		send_request(ACT_SET, 8'd63, 32'hA5A5_A5A5, '0);
		send_request(ACT_SET_SIZE, '0, '0, 9'd256);
		send_request(ACT_SET_SIZE, '0, '0, 9'd511);
		send_request(ACT_TEST_AND_SET, 8'd255, 32'hFFFF_FFFF, '0);
		send_request(ACT_FIRST_UNUSED, 8'd255, 32'hFFFF_FFFF, 9'd511);
		send_request(ACT_LAST_UNUSED, '0, 32'h1234_5678, '0);
		send_request(ACT_INIT, '0, '0, '0);
	endtask

	// A three-slot table grown two at a time: fill it, then overflow by add and by index.
	task automatic test_small_table();
		configure_table(3, 2, 1);
		write_register(CFG_SPARE_INDEX, 511);
		send_request(ACT_INIT, '0, '0, '0);
		send_request(ACT_ADD, '0, 32'h1, '0);
		send_request(ACT_ADD, '0, 32'h2, '0);
		send_request(ACT_ADD, '0, 32'h3, '0);
		send_request(ACT_ADD, '0, 32'h4, '0);
		send_request(ACT_TEST_AND_SET, 8'd200, 32'h9, '0);
	endtask

	// Register values at and past their nominal range.
	task automatic test_register_extremes();
		// Maximum below the step: init refused.
		configure_table(1, 2, 0);
		send_request(ACT_INIT, '0, '0, '0);
		// An initial size past capacity is cut to capacity.
		configure_table(511, 0, 511);
		send_request(ACT_INIT, '0, '0, '0);
		send_request(ACT_ADD, '0, 32'h8000_0001, '0);
		configure_table(0, 256, 0);
		send_request(ACT_INIT, '0, '0, '0);
		// A zero step gives an empty table that can never grow.
		configure_table(0, 0, 0);
		send_request(ACT_INIT, '0, '0, '0);
		send_request(ACT_ADD, '0, 32'h7, '0);
		send_request(ACT_SET_SIZE, '0, '0, 9'd1);
	endtask

	// Mostly meaningful traffic around the current size, with some full-range noise.
	task automatic run_random_items(input int count);
		int choice;
		int span;
		logic [ACT_W-1:0]   act;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] val;
		logic [SIZE_W-1:0]  req;
		send_request(ACT_INIT, '0, '0, '0);
		for (int n = 0; n < count; n++) begin
			choice = $urandom_range(99);
			if (choice < 42)
				act = ACT_ADD;
			else if (choice < 58)
				act = ACT_SET;
			else if (choice < 74)
				act = ACT_TEST_AND_SET;
			else if (choice < 87)
				act = ACT_SET_SIZE;
			else if (choice < 95)
				act = ACT_INIT;
			else
				act = ACT_W'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED));

			span = model_size + cfg_step;
			if (span > CAPACITY - 1)
				span = CAPACITY - 1;
			if ($urandom_range(3) == 0)
				idx = IDX_W'($urandom_range(CAPACITY - 1));
			else
				idx = IDX_W'($urandom_range(span));

			case ($urandom_range(9))
				0, 1:    val = '0;
				2:       val = '1;
				default: val = VALUE_W'($urandom);
			endcase

			span = model_size + 2 * cfg_step + 1;
			if (span > 511)
				span = 511;
			if ($urandom_range(3) == 0)
				req = SIZE_W'($urandom_range(511));
			else
				req = SIZE_W'($urandom_range(span));

			send_request(act, idx, val, req);
		end
	endtask

	// Eight phases, each with its own register setting and one of four idling patterns.
	task automatic test_random_traffic();
		int max_e;
		int step;
		int init_e;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin max_e = 256; step = 32; init_e = 0; end
				2: begin max_e = 511; step = 256; init_e = 0; end
				3: begin max_e = 8; step = 1; init_e = 511; end
				5: begin max_e = 256; step = 1; init_e = 0; end
				6: begin
					max_e  = $urandom_range(511);
					step   = $urandom_range(511);
					init_e = $urandom_range(511);
				end
				7: begin max_e = 2; step = 2; init_e = 1; end
				default: begin
					max_e  = $urandom_range(16, 1);
					step   = $urandom_range(4, 1);
					init_e = $urandom_range(max_e);
				end
			endcase
			configure_table(max_e, step, init_e);
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
				default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
			endcase
			run_random_items(125);
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------------------

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.action         = ACT_INIT;
		req_ch.slot_index     = '0;
		req_ch.handle_value   = '0;
		req_ch.requested_size = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = CFG_MAX_ENTRIES;
		cfg_ch.data           = '0;
		sender_idle_pct       = 0;
		receiver_stall_pct    = 0;

		// State after reset: empty table of size zero, registers at their reset values.
		clear_slots();
		model_size   = 0;
		model_free   = 0;
		model_lowest = 0;
		cfg_max      = int'(RST_MAX_ENTRIES);
		cfg_step     = int'(RST_GROW_STEP);
		cfg_initial  = int'(RST_INITIAL_ENTRIES);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_small_table();
		test_register_extremes();
		test_random_traffic();

		wait_until_drained();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: lowest_free_slot_table.f
hw/rtl/lfst_pkg.sv
hw/rtl/lfst_if.sv
hw/rtl/lfst_ram.sv
hw/rtl/lfst_ctrl.sv
hw/rtl/lfst_dp.sv
hw/rtl/lowest_free_slot_table.sv
hw/rtl/lfst_checker.sv
bench/lowest_free_slot_table_tb.sv
